// ----- hw/rtl/byte_ring_buffer_macros.svh -----
// ----------------------------------------------------------------------------
// byte ring buffer assertion macros
// shared property forms for the checker, clocked on clk and gated by rst
// ----------------------------------------------------------------------------
`ifndef BYTE_RING_BUFFER_MACROS_SVH
`define BYTE_RING_BUFFER_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define BRB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define BRB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/brb_pkg.sv -----
// ----------------------------------------------------------------------------
// brb_pkg
// operation codes, beat payload types and controller/datapath interface
// ----------------------------------------------------------------------------
package brb_pkg;

  localparam logic [2:0] FN_PUSH  = 3'd0;
  localparam logic [2:0] FN_POP   = 3'd1;
  localparam logic [2:0] FN_PEEK  = 3'd2;
  localparam logic [2:0] FN_SKIP  = 3'd3;
  localparam logic [2:0] FN_ADV   = 3'd4;
  localparam logic [2:0] FN_CLEAR = 3'd5;

  typedef struct packed {
    logic [2:0]  func;
    logic [7:0]  data_byte;
    logic [11:0] count;
  } item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        last;
    logic [11:0] done_count;
    logic [11:0] used_space;
    logic [11:0] free_space;
    logic [11:0] contig_read;
    logic [11:0] contig_write;
  } result_t;

  typedef struct packed {
    logic clr_wr;
    logic capture;
    logic red_mul;
    logic red_sub;
    logic exec;
    logic rd_issue;
    logic emit_byte;
    logic emit_stat;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic run_go;
    logic rem_rd_zero;
    logic out_free;
  } stat_t;

endpackage

// ----- hw/rtl/brb_ctrl.sv -----
// ----------------------------------------------------------------------------
// brb_ctrl
// sequencer: store clearing sweep, item capture, execute and result beats
// ----------------------------------------------------------------------------
module brb_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  input  logic [2:0]     item_func,
  input  brb_pkg::stat_t stat,
  output brb_pkg::cmd_t  cmd,
  output logic           item_stall
);

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_MUL,
    S_SUB,
    S_EXEC,
    S_ISSUE,
    S_STREAM,
    S_STAT
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_CLR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (item_valid) begin
          cmd.capture = 1'b1;
          // advance write needs its count reduced modulo the depth first
          state_next  = (item_func == brb_pkg::FN_ADV) ? S_MUL : S_EXEC;
        end
      end
      S_MUL: begin
        cmd.red_mul = 1'b1;
        state_next  = S_SUB;
      end
      S_SUB: begin
        cmd.red_sub = 1'b1;
        state_next  = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = stat.run_go ? S_ISSUE : S_STAT;
      end
      S_ISSUE: begin
        cmd.rd_issue = 1'b1;
        state_next   = S_STREAM;
      end
      S_STREAM: begin
        if (stat.out_free) begin
          cmd.emit_byte = 1'b1;
          if (!stat.rem_rd_zero) begin
            cmd.rd_issue = 1'b1;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_STAT: begin
        if (stat.out_free) begin
          cmd.emit_stat = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign item_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- hw/rtl/brb_dp.sv -----
// ----------------------------------------------------------------------------
// brb_dp
// byte store, read/write pointers, run counters, status and result register
// ----------------------------------------------------------------------------
module brb_dp #(
  parameter int DEPTH   = 4096,
  parameter int MAX_RUN = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  brb_pkg::item_t   item,
  input  brb_pkg::cmd_t    cmd,
  output brb_pkg::stat_t   stat,
  input  logic             result_stall,
  output logic             result_valid,
  output brb_pkg::result_t result
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = AW + 1;
  localparam int XW   = (CW > 12) ? CW : 12;
  localparam int RW   = $clog2(MAX_RUN + 1);
  localparam int SH   = 12 + AW;
  localparam int MULT = ((2 ** SH) + DEPTH - 1) / DEPTH;

  localparam logic [CW-1:0] DEPTH_C   = CW'(DEPTH);
  localparam logic [13:0]   MULT_C    = 14'(MULT);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [11:0]   RUN_CAP   = 12'(MAX_RUN);

  function automatic logic [AW-1:0] add_mod(input logic [AW-1:0] p,
                                            input logic [AW-1:0] v);
    logic [CW-1:0] s;
    s = {1'b0, p} + {1'b0, v};
    if (s >= DEPTH_C) begin
      s = s - DEPTH_C;
    end
    return s[AW-1:0];
  endfunction

  function automatic logic [11:0] fit12(input logic [CW-1:0] v);
    logic [XW-1:0] t;
    t = XW'(v);
    return t[11:0];
  endfunction

  function automatic logic [AW-1:0] to_addr(input logic [XW-1:0] v);
    return v[AW-1:0];
  endfunction

  logic [7:0]    mem [DEPTH];
  logic [7:0]    rd_data;
  logic [AW-1:0] rp;
  logic [AW-1:0] wp;
  logic [AW-1:0] pos;
  logic [AW-1:0] clr_addr;
  logic [2:0]    func_r;
  logic [7:0]    data_r;
  logic [11:0]   count_r;
  logic [25:0]   prod;
  logic [AW-1:0] adv_off;
  logic [11:0]   done_cnt;
  logic [RW-1:0] rem_rd;
  logic [RW-1:0] rem_out;

  logic [CW-1:0] used;
  logic [CW-1:0] free_cnt;
  logic [CW-1:0] crd;
  logic [CW-1:0] cwr;
  logic [XW-1:0] used_x;
  logic [XW-1:0] count_x;
  logic [11:0]   cap12;
  logic [XW-1:0] run_x;
  logic [RW-1:0] run_len;
  logic          is_run;
  logic          push_ok;
  logic          skip_ok;
  logic [11:0]   q12;
  logic [11:0]   qd;
  logic [11:0]   rem12;
  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;
  logic          out_free;
  brb_pkg::result_t status_res;
  brb_pkg::result_t byte_res;

  // occupancy and spans from the current pointers
  always_comb begin
    if (wp >= rp) begin
      used = {1'b0, wp} - {1'b0, rp};
    end else begin
      used = {1'b0, wp} + DEPTH_C - {1'b0, rp};
    end
    free_cnt = DEPTH_C - CW'(1) - used;
    crd      = (rp > wp) ? (DEPTH_C - {1'b0, rp}) : used;
    cwr      = (wp >= rp) ? (DEPTH_C - {1'b0, wp} - CW'(rp == '0)) : free_cnt;
  end

  always_comb begin
    used_x  = XW'(used);
    count_x = XW'(count_r);
    cap12   = (count_r < RUN_CAP) ? count_r : RUN_CAP;
    run_x   = (XW'(cap12) < used_x) ? XW'(cap12) : used_x;
    run_len = run_x[RW-1:0];
    is_run  = (func_r == brb_pkg::FN_POP) || (func_r == brb_pkg::FN_PEEK);
    push_ok = (used != (DEPTH_C - CW'(1)));
    skip_ok = (count_x <= used_x);
  end

  // count mod depth by reciprocal multiply, second stage
  always_comb begin
    q12   = 12'(prod >> SH);
    qd    = 12'(q12 * DEPTH_C);
    rem12 = count_r - qd;
  end

  always_comb begin
    status_res              = '0;
    status_res.last         = 1'b1;
    status_res.done_count   = done_cnt;
    status_res.used_space   = fit12(used);
    status_res.free_space   = fit12(free_cnt);
    status_res.contig_read  = fit12(crd);
    status_res.contig_write = fit12(cwr);
    if (rem_out == RW'(1)) begin
      byte_res = status_res;
    end else begin
      byte_res = '0;
    end
    byte_res.out_byte   = rd_data;
    byte_res.byte_valid = 1'b1;
  end

  assign out_free         = !result_valid || !result_stall;
  assign stat.clr_last    = (clr_addr == LAST_ADDR);
  assign stat.run_go      = is_run && (run_x != '0);
  assign stat.rem_rd_zero = (rem_rd == '0);
  assign stat.out_free    = out_free;

  // single write port shared by the clearing sweep and push
  always_comb begin
    we    = cmd.clr_wr || (cmd.exec && (func_r == brb_pkg::FN_PUSH) && push_ok);
    waddr = cmd.clr_wr ? clr_addr : wp;
    wdata = cmd.clr_wr ? 8'd0 : data_r;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd_issue) begin
      rd_data <= mem[pos];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rp       <= '0;
      wp       <= '0;
      clr_addr <= '0;
      rem_rd   <= '0;
      rem_out  <= '0;
    end else begin
      if (cmd.clr_wr) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (cmd.exec) begin
        rem_rd  <= run_len;
        rem_out <= run_len;
        case (func_r) inside
          brb_pkg::FN_PUSH: begin
            if (push_ok) begin
              wp <= add_mod(wp, AW'(1));
            end
          end
          brb_pkg::FN_POP: begin
            rp <= add_mod(rp, to_addr(run_x));
          end
          brb_pkg::FN_SKIP: begin
            if (skip_ok) begin
              rp <= add_mod(rp, to_addr(count_x));
            end
          end
          brb_pkg::FN_ADV: begin
            wp <= add_mod(wp, adv_off);
          end
          brb_pkg::FN_CLEAR: begin
            rp <= '0;
            wp <= '0;
          end
          default: begin
          end
        endcase
      end
      if (cmd.rd_issue) begin
        rem_rd <= rem_rd - RW'(1);
      end
      if (cmd.emit_byte) begin
        rem_out <= rem_out - RW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r  <= item.func;
      data_r  <= item.data_byte;
      count_r <= item.count;
    end
    if (cmd.red_mul) begin
      prod <= count_r * MULT_C;
    end
    if (cmd.red_sub) begin
      adv_off <= to_addr(XW'(rem12));
    end
    if (cmd.exec) begin
      pos <= rp;
      case (func_r) inside
        brb_pkg::FN_PUSH: done_cnt <= push_ok ? 12'd1 : 12'd0;
        brb_pkg::FN_POP, brb_pkg::FN_PEEK: done_cnt <= 12'(run_len);
        brb_pkg::FN_SKIP: done_cnt <= skip_ok ? count_r : 12'd0;
        default: done_cnt <= 12'd0;
      endcase
    end else if (cmd.rd_issue) begin
      pos <= add_mod(pos, AW'(1));
    end
  end

  // result register, loaded only when empty or being taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit_byte || cmd.emit_stat) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_byte) begin
      result <= byte_res;
    end else if (cmd.emit_stat) begin
      result <= status_res;
    end
  end

endmodule

// ----- hw/rtl/byte_ring_buffer.sv -----
// ----------------------------------------------------------------------------
// byte_ring_buffer
// circular byte store keeping one slot free: push, pop/peek runs, skip,
// unchecked write advance and clear, each item closing with a status beat
// ----------------------------------------------------------------------------
//  channel  | handshake                   | payload
//  ---------+-----------------------------+---------------------------------
//  item     | item_valid / item_stall     | brb_pkg::item_t   (func, byte, count)
//  result   | result_valid / result_stall | brb_pkg::result_t (byte, status)
//
//  one item at a time: push, skip, clear capture, execute, send a status beat;
//  advance write adds two reciprocal multiply steps reducing count mod DEPTH
//  a pop or peek streams its bytes from the registered read port of the store,
//  one byte per cycle while result_stall does not hold them
//  after reset a zeroing sweep of the whole store runs before the first item
//  result_stall only holds the result register; the sequencer waits on it
// ----------------------------------------------------------------------------
module byte_ring_buffer #(
  parameter int DEPTH   = 4096,
  parameter int MAX_RUN = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  brb_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output brb_pkg::result_t result
);

  brb_pkg::cmd_t  cmd;
  brb_pkg::stat_t stat;

  brb_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_func  (item.func),
    .stat       (stat),
    .cmd        (cmd),
    .item_stall (item_stall)
  );

  brb_dp #(
    .DEPTH   (DEPTH),
    .MAX_RUN (MAX_RUN)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cmd          (cmd),
    .stat         (stat),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

// ----- hw/rtl/brb_chk.sv -----
// ----------------------------------------------------------------------------
// brb_chk
// port-level checks on the byte ring buffer, bound to the top level
// ----------------------------------------------------------------------------
`include "byte_ring_buffer_macros.svh"

module brb_chk #(
  parameter int DEPTH   = 4096,
  parameter int MAX_RUN = 64
) (
  input logic             clk,
  input logic             rst,
  input logic             item_valid,
  input logic             item_stall,
  input logic             result_valid,
  input logic             result_stall,
  input brb_pkg::result_t result
);

  logic res_held;
  logic item_take;
  logic mid_beat;
  logic mid_clean;
  logic last_beat;
  logic space_ok;
  logic run_end;
  logic run_ok;

  assign res_held  = result_valid && result_stall;
  assign item_take = item_valid && !item_stall;
  assign mid_beat  = result_valid && !result.last;
  assign mid_clean = result.byte_valid && result.done_count == 12'd0 &&
                     result.used_space == 12'd0 && result.free_space == 12'd0;
  assign last_beat = result_valid && result.last;
  assign space_ok  = 12'(result.used_space + result.free_space) == 12'(DEPTH - 1);
  assign run_end   = last_beat && result.byte_valid;
  assign run_ok    = result.done_count != 12'd0 && result.done_count <= 12'(MAX_RUN);

  `BRB_ASSERT_NEXT(a_hold, res_held, result_valid && $stable(result), "stalled beat changed")

  `BRB_ASSERT_NEXT(a_busy, item_take, item_stall, "item taken in back to back cycles")

  `BRB_ASSERT_NOW(a_mid_run, mid_beat, mid_clean, "mid-run beat carries status or no byte")

  `BRB_ASSERT_NOW(a_space, last_beat, space_ok, "used plus free disagrees with depth")

  `BRB_ASSERT_NOW(a_run_len, run_end, run_ok, "run length out of range")

endmodule

bind byte_ring_buffer brb_chk #(
  .DEPTH   (DEPTH),
  .MAX_RUN (MAX_RUN)
) u_brb_chk (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

// ----- test/byte_ring_buffer_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_ring_buffer_tb
// drives push, pop, peek, skip, write-advance, clear and spare op codes into
// the ring buffer with random gaps on the item side and random stalls on the
// result side; every result beat is checked against a local copy of the ring
// ----------------------------------------------------------------------------
module byte_ring_buffer_tb;

  localparam int RING_DEPTH = 4096;
  localparam int RUN_MAX    = 64;
  localparam int RAND_OPS   = 370;
  localparam int MAX_PRINTS = 50;

  // op codes the block has no use for
  localparam logic [2:0] FN_SPARE6 = 3'd6;
  localparam logic [2:0] FN_SPARE7 = 3'd7;

  logic             clk;
  logic             rst;
  logic             item_valid = 1'b0;
  logic             item_stall;
  brb_pkg::item_t   item = '0;
  logic             result_valid;
  logic             result_stall = 1'b0;
  brb_pkg::result_t result;

  byte_ring_buffer #(
    .DEPTH  (RING_DEPTH),
    .MAX_RUN(RUN_MAX)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

  // local copy of the ring
  logic [7:0]  ring_mem [RING_DEPTH];
  int unsigned rd_ptr;
  int unsigned wr_ptr;

  brb_pkg::item_t   ops_to_send [$];
  brb_pkg::result_t beats_due [$];
  int unsigned ops_total;
  int unsigned ops_taken;
  int unsigned mismatches;

  int unsigned send_idle;
  int unsigned send_calm;
  int unsigned hold_left;
  int unsigned hold_calm;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    #15ms;
    $display("tb: failure");
    $finish;
  end

  task automatic flag_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
  endtask

  task automatic check_field(input string what, input int unsigned got,
                             input int unsigned want);
    if (got != want)
      flag_mismatch(what, got, want);
  endtask

  function automatic int unsigned ring_used();
    return (wr_ptr >= rd_ptr) ? wr_ptr - rd_ptr : RING_DEPTH - rd_ptr + wr_ptr;
  endfunction

  function automatic brb_pkg::result_t status_beat(input logic [7:0] b,
                                                   input logic bv,
                                                   input int unsigned done);
    brb_pkg::result_t r;
    int unsigned      used;
    int unsigned      spare;
    used = ring_used();
    spare = RING_DEPTH - 1 - used;
    r.out_byte = b;
    r.byte_valid = bv;
    r.last = 1'b1;
    r.done_count = 12'(done);
    r.used_space = 12'(used);
    r.free_space = 12'(spare);
    r.contig_read = 12'((rd_ptr > wr_ptr) ? RING_DEPTH - rd_ptr : used);
    if (wr_ptr >= rd_ptr)
      r.contig_write = 12'(RING_DEPTH - wr_ptr - ((rd_ptr == 0) ? 1 : 0));
    else
      r.contig_write = 12'(spare);
    return r;
  endfunction

  // apply one accepted item to the local ring and queue the beats it owes
  task automatic ring_step(input brb_pkg::item_t it);
    int unsigned      n;
    int unsigned      done;
    int unsigned      pos;
    brb_pkg::result_t r;
    done = 0;
    case (it.func)
      brb_pkg::FN_PUSH: begin
        if (ring_used() < RING_DEPTH - 1) begin
          ring_mem[wr_ptr] = it.data_byte;
          wr_ptr = (wr_ptr + 1) % RING_DEPTH;
          done = 1;
        end
      end
      brb_pkg::FN_POP, brb_pkg::FN_PEEK: begin
        n = it.count;
        if (n > RUN_MAX) n = RUN_MAX;
        if (n > ring_used()) n = ring_used();
        if (n > 0) begin
          pos = rd_ptr;
          if (it.func == brb_pkg::FN_POP)
            rd_ptr = (rd_ptr + n) % RING_DEPTH;
          for (int i = 0; i < n; i++) begin
            if (i + 1 == n) begin
              r = status_beat(ring_mem[pos], 1'b1, n);
            end else begin
              r = '0;
              r.out_byte = ring_mem[pos];
              r.byte_valid = 1'b1;
            end
            beats_due.push_back(r);
            pos = (pos + 1) % RING_DEPTH;
          end
          return;
        end
      end
      brb_pkg::FN_SKIP: begin
        if (it.count <= ring_used()) begin
          rd_ptr = (rd_ptr + it.count) % RING_DEPTH;
          done = it.count;
        end
      end
      brb_pkg::FN_ADV: wr_ptr = (wr_ptr + it.count) % RING_DEPTH;
      brb_pkg::FN_CLEAR: begin
        rd_ptr = 0;
        wr_ptr = 0;
      end
      default: ;
    endcase
    beats_due.push_back(status_beat(8'h00, 1'b0, done));
  endtask

  // mostly short gaps, now and then a long one
  function automatic int unsigned idle_span();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 14);
  endfunction

  function automatic logic [11:0] run_count();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 12'($urandom_range(1, 8));
    if (r < 85) return 12'($urandom_range(9, 80));
    if (r < 95) return 12'd0;
    return 12'($urandom_range(0, 4095));
  endfunction

  task automatic queue_op(input logic [2:0] f, input logic [7:0] d,
                          input logic [11:0] c);
    brb_pkg::item_t it;
    it.func = f;
    it.data_byte = d;
    it.count = c;
    ops_to_send.push_back(it);
  endtask

  // item side
  always @(posedge clk) begin
    brb_pkg::item_t next_item;
    logic           next_valid;
    if (rst) begin
      item_valid <= 1'b0;
      item <= '0;
      send_idle = 0;
      send_calm = 0;
    end else if (!(item_valid && item_stall)) begin
      if (item_valid) begin
        ring_step(item);
        ops_taken++;
      end
      next_valid = 1'b0;
      next_item = item;
      if (send_calm > 0)
        send_calm--;
      else if ($urandom_range(0, 49) == 0)
        send_calm = $urandom_range(20, 60);
      if (send_idle > 0) begin
        send_idle--;
      end else if (ops_to_send.size() > 0) begin
        next_item = ops_to_send.pop_front();
        next_valid = 1'b1;
        send_idle = (send_calm > 0) ? 0 : idle_span();
      end
      item_valid <= next_valid;
      item <= next_item;
    end
  end

  // result side
  always @(posedge clk) begin
    brb_pkg::result_t want;
    logic             next_stall;
    if (rst) begin
      result_stall <= 1'b0;
      hold_left = 0;
      hold_calm = 0;
    end else begin
      if (result_valid && !result_stall) begin
        if (beats_due.size() == 0) begin
          flag_mismatch("result beat with nothing due, out_byte", result.out_byte, 0);
        end else begin
          want = beats_due.pop_front();
          check_field("out_byte", result.out_byte, want.out_byte);
          check_field("byte_valid", result.byte_valid, want.byte_valid);
          check_field("last", result.last, want.last);
          check_field("done_count", result.done_count, want.done_count);
          check_field("used_space", result.used_space, want.used_space);
          check_field("free_space", result.free_space, want.free_space);
          check_field("contig_read", result.contig_read, want.contig_read);
          check_field("contig_write", result.contig_write, want.contig_write);
        end
      end
      if (hold_calm > 0)
        hold_calm--;
      else if ($urandom_range(0, 49) == 0)
        hold_calm = $urandom_range(20, 60);
      if (hold_left > 0) begin
        hold_left--;
        next_stall = 1'b1;
      end else begin
        next_stall = 1'b0;
        hold_left = (hold_calm > 0) ? 0 : idle_span();
      end
      result_stall <= next_stall;
    end
  end

  initial begin
    int unsigned r;
    mismatches = 0;
    ops_taken = 0;
    rd_ptr = 0;
    wr_ptr = 0;
    foreach (ring_mem[i]) ring_mem[i] = 8'h00;

    // directed: empty runs, byte extremes, clamping, full ring, wrap
    queue_op(brb_pkg::FN_POP,   8'h00, 12'd5);
    queue_op(brb_pkg::FN_PEEK,  8'h00, 12'd0);
    queue_op(brb_pkg::FN_PUSH,  8'h00, 12'd0);
    queue_op(brb_pkg::FN_PUSH,  8'hFF, 12'hFFF);
    queue_op(brb_pkg::FN_PUSH,  8'h5A, 12'd0);
    queue_op(brb_pkg::FN_PEEK,  8'h00, 12'd2);
    queue_op(brb_pkg::FN_POP,   8'h00, 12'd4095);
    queue_op(brb_pkg::FN_SKIP,  8'h00, 12'd4095);
    queue_op(brb_pkg::FN_SKIP,  8'h00, 12'd0);
    queue_op(brb_pkg::FN_ADV,   8'h00, 12'd4095);
    queue_op(brb_pkg::FN_PUSH,  8'hA5, 12'd0);
    queue_op(brb_pkg::FN_PEEK,  8'h00, 12'd64);
    queue_op(brb_pkg::FN_POP,   8'h00, 12'd65);
    queue_op(brb_pkg::FN_SKIP,  8'h00, 12'd4000);
    queue_op(brb_pkg::FN_SKIP,  8'h00, 12'd31);
    queue_op(FN_SPARE6, 8'hFF, 12'd4095);
    queue_op(FN_SPARE7, 8'h00, 12'd0);
    queue_op(brb_pkg::FN_CLEAR, 8'h00, 12'd0);
    queue_op(brb_pkg::FN_ADV,   8'h00, 12'd4094);
    queue_op(brb_pkg::FN_SKIP,  8'h00, 12'd4090);
    queue_op(brb_pkg::FN_PUSH,  8'h81, 12'd0);
    queue_op(brb_pkg::FN_PUSH,  8'h7E, 12'd0);
    queue_op(brb_pkg::FN_PUSH,  8'hC3, 12'd0);
    queue_op(brb_pkg::FN_POP,   8'h00, 12'd10);
    queue_op(brb_pkg::FN_CLEAR, 8'h00, 12'd0);

    repeat (RAND_OPS) begin
      r = $urandom_range(0, 99);
      if (r < 45)
        queue_op(brb_pkg::FN_PUSH, 8'($urandom_range(0, 255)),
                 12'($urandom_range(0, 4095)));
      else if (r < 60)
        queue_op(brb_pkg::FN_POP, 8'($urandom_range(0, 255)), run_count());
      else if (r < 70)
        queue_op(brb_pkg::FN_PEEK, 8'($urandom_range(0, 255)), run_count());
      else if (r < 80)
        queue_op(brb_pkg::FN_SKIP, 8'($urandom_range(0, 255)),
                 ($urandom_range(0, 4) == 0) ? 12'($urandom_range(0, 4095))
                                             : 12'($urandom_range(0, 40)));
      else if (r < 92)
        queue_op(brb_pkg::FN_ADV, 8'($urandom_range(0, 255)),
                 ($urandom_range(0, 4) == 0) ? 12'($urandom_range(0, 4095))
                                             : 12'($urandom_range(0, 100)));
      else if (r < 96)
        queue_op(brb_pkg::FN_CLEAR, 8'($urandom_range(0, 255)),
                 12'($urandom_range(0, 4095)));
      else
        queue_op($urandom_range(0, 1) ? FN_SPARE6 : FN_SPARE7,
                 8'($urandom_range(0, 255)), 12'($urandom_range(0, 4095)));
    end
    ops_total = ops_to_send.size();

    @(negedge clk);
    while (rst || ops_taken < ops_total || beats_due.size() != 0)
      @(negedge clk);
    // anything arriving now is a stray beat
    repeat (200) @(negedge clk);
    if (beats_due.size() != 0)
      flag_mismatch("result beats never produced", beats_due.size(), 0);

    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
